@@ rtl/core/kmms_pkg.sv @@
package kmms_pkg;

    typedef logic [7:0] char_t;
    typedef logic [5:0] slot_t;
    typedef logic [6:0] len_t;
    typedef logic [6:0] start_t;
    typedef logic [6:0] count_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MOTIF_LENGTH       = 1'b0,
        REG_MISMATCH_ALLOWANCE = 1'b1
    } reg_index_t;

    localparam logic OP_MOTIF_LOAD = 1'b0;
    localparam logic OP_READ_CHAR  = 1'b1;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic  shift;   // read character taken: row moves one place
        logic  load;    // motif character written at slot
        logic  adv;     // pipeline advances: capture mismatch flag
        slot_t slot;
        char_t ch;
        len_t  len;     // motif length in use, already clamped
    } cell_ctrl_t;

    // one token per accepted read character
    typedef struct packed {
        logic   valid;
        logic   win;    // a full window ended on this character
        logic   last;
        start_t start;
    } token_t;

endpackage

@@ rtl/core/k_mismatch_motif_search.sv @@
// k-mismatch motif search.
// Input stream (s_axis_*): tuser = opcode. Opcode 0 writes char to motif slot;
// opcode 1 is a read character, tlast marking the final one of the read.
// Config port: cfg_wr_en/cfg_index/cfg_data write motif_length (0) or
// mismatch_allowance (1); write only while no read is in flight.
// Output stream (m_axis_*): one item per read, after the read's last char:
// found flag in tuser, best start and its mismatch count in tdata.
// Each window is checked against the motif as it stands when the window ends.
// Throughput: one item per cycle while the output does not stall; the row of cells
// compares all motif places at once and the mismatch count goes through a three-level
// registered adder, in step with the token pipeline.
// Stall: a held output only blocks the input when a further result arrives at
// the last stage; until then items keep flowing behind it.
// Reset: motif length 1, allowance 0, read state cleared, output empty.
// Motif contents are not cleared by reset.
module k_mismatch_motif_search #(
    parameter int MAX_MOTIF = 64,
    parameter int MAX_READ  = 128
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] char_value, [13:8] motif_slot, zero fill
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    input  logic        s_axis_tlast,   // read_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] match_start, [13:7] mismatch_count, zero fill
    output logic [0:0]  m_axis_tuser,   // [0] found

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int CW = $clog2(MAX_MOTIF + 1);
    localparam int PW = $clog2(MAX_READ + 1);
    localparam int XW = ((PW > 7) ? PW : 7) + 1;

    typedef logic [XW-1:0] pos_ext_t;

    // configuration
    kmms_pkg::len_t len_cfg_reg;
    logic [6:0]     allow_reg;
    kmms_pkg::len_t len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= 7'd1;
            allow_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                kmms_pkg::REG_MOTIF_LENGTH:       len_cfg_reg <= cfg_data;
                kmms_pkg::REG_MISMATCH_ALLOWANCE: allow_reg   <= cfg_data;
                default:                          ;
            endcase
        end
    end

    // 0 counts as 1, anything above the row length as the row length
    always_comb
    begin
        priority if (len_cfg_reg == '0)
        begin
            len_eff = 7'd1;
        end
        else if (32'(len_cfg_reg) > MAX_MOTIF)
        begin
            len_eff = kmms_pkg::len_t'(MAX_MOTIF);
        end
        else
        begin
            len_eff = len_cfg_reg;
        end
    end

    // input side
    kmms_pkg::char_t in_char;
    kmms_pkg::slot_t in_slot;
    logic            adv;
    logic            stall;
    logic            accept;
    logic            rd_accept;
    logic            store;

    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   pos_next;
    pos_ext_t        pos1;

    kmms_pkg::token_t tok0_next;
    kmms_pkg::token_t tok_reg [5];

    assign in_char = s_axis_tdata[7:0];
    assign in_slot = s_axis_tdata[13:8];

    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign rd_accept     = accept && (s_axis_tuser[0] == kmms_pkg::OP_READ_CHAR);
    assign store         = rd_accept && (32'(pos_reg) < MAX_READ);
    assign pos1          = pos_ext_t'(pos_reg) + pos_ext_t'(1);

    always_comb
    begin
        pos_next = pos_reg;
        if (rd_accept)
        begin
            if (s_axis_tlast)
            begin
                pos_next = '0;
            end
            else if (store)
            begin
                pos_next = PW'(pos1);
            end
        end
    end

    always_comb
    begin
        tok0_next.valid = rd_accept;
        tok0_next.last  = s_axis_tlast;
        tok0_next.win   = store && (pos1 >= pos_ext_t'(len_eff));
        tok0_next.start = kmms_pkg::start_t'(pos1 - pos_ext_t'(len_eff));
    end

    // token pipeline, aligned with the cells and the adder levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int s = 0; s < 5; s++)
            begin
                tok_reg[s].valid <= 1'b0;
            end
        end
        else if (adv)
        begin
            pos_reg    <= pos_next;
            tok_reg[0] <= tok0_next;
            for (int s = 1; s < 5; s++)
            begin
                tok_reg[s] <= tok_reg[s-1];
            end
        end
    end

    // row of cells
    kmms_pkg::cell_ctrl_t cell_ctrl;
    kmms_pkg::char_t      char_chain [MAX_MOTIF+1];
    logic [MAX_MOTIF-1:0] mismatch_bits;

    always_comb
    begin
        cell_ctrl.shift = store;
        cell_ctrl.load  = accept && (s_axis_tuser[0] == kmms_pkg::OP_MOTIF_LOAD);
        cell_ctrl.adv   = adv;
        cell_ctrl.slot  = in_slot;
        cell_ctrl.ch    = in_char;
        cell_ctrl.len   = len_eff;
    end

    assign char_chain[MAX_MOTIF] = in_char;

    for (genvar j = 0; j < MAX_MOTIF; j++)
    begin : g_cell
        kmms_cell #(
            .IDX (j)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .char_in  (char_chain[j+1]),
            .char_out (char_chain[j]),
            .mismatch (mismatch_bits[j])
        );
    end

    logic [CW-1:0] total;

    kmms_popcount #(
        .N (MAX_MOTIF)
    ) u_popcount (
        .clk   (clk),
        .en    (adv),
        .bits  (mismatch_bits),
        .total (total)
    );

    // best tracking and output register
    logic                 best_found_reg;
    kmms_pkg::start_t     best_start_reg;
    logic [CW-1:0]        best_mm_reg;
    logic                 cand;
    logic                 nf;
    kmms_pkg::start_t     ns;
    logic [CW-1:0]        nm;
    logic                 emit;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    kmms_pkg::start_t     out_start_reg;
    kmms_pkg::count_t     out_count_reg;

    assign emit  = tok_reg[4].valid && tok_reg[4].last;
    assign stall = emit && out_valid_reg && !m_axis_tready;
    assign adv   = !stall;

    // strictly fewer mismatches wins, so the earliest start is kept on ties
    assign cand = tok_reg[4].valid && tok_reg[4].win
                  && (32'(total) <= 32'(allow_reg))
                  && (!best_found_reg || (total < best_mm_reg));
    assign nf   = cand || best_found_reg;
    assign ns   = cand ? tok_reg[4].start : best_start_reg;
    assign nm   = cand ? total : best_mm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_start_reg <= '0;
            best_mm_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv && emit)
            begin
                best_found_reg <= 1'b0;
                best_start_reg <= '0;
                best_mm_reg    <= '0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                if (adv && cand)
                begin
                    best_found_reg <= 1'b1;
                    best_start_reg <= ns;
                    best_mm_reg    <= nm;
                end
                if (m_axis_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_found_reg <= nf;
            out_start_reg <= nf ? ns : '0;
            out_count_reg <= nf ? kmms_pkg::count_t'(nm) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_start_reg};

endmodule

@@ rtl/core/kmms_cell.sv @@
module kmms_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  kmms_pkg::cell_ctrl_t   ctrl,
    input  kmms_pkg::char_t        char_in,    // from the neighbour above
    output kmms_pkg::char_t        char_out,
    output logic                   mismatch
);

    kmms_pkg::char_t motif_reg;
    kmms_pkg::char_t char_reg;
    logic            mismatch_reg;
    logic            in_win;
    logic            is_tail;

    assign in_win  = 32'(ctrl.len) > IDX;
    assign is_tail = 32'(ctrl.len) == IDX + 1;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && (32'(ctrl.slot) == IDX))
        begin
            motif_reg <= ctrl.ch;
        end
        if (ctrl.shift)
        begin
            // newest character enters at the tail, older ones move down
            char_reg <= is_tail ? ctrl.ch : char_in;
        end
        if (ctrl.adv)
        begin
            mismatch_reg <= in_win && (char_reg != motif_reg);
        end
    end

    assign char_out = char_reg;
    assign mismatch = mismatch_reg;

endmodule

@@ rtl/core/kmms_popcount.sv @@
module kmms_popcount #(
    parameter int N = 64,
    localparam int CW = $clog2(N + 1)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [N-1:0]  bits,
    output logic [CW-1:0] total
);

    // three registered levels: 8 bits, 8 groups, up to 4 blocks
    localparam int NG2 = (N + 63) / 64;
    localparam int NG  = NG2 * 8;

    typedef logic [NG*8-1:0] pad_t;

    pad_t          pad;
    logic [3:0]    grp_reg [NG];
    logic [3:0]    grp_next [NG];
    logic [6:0]    mid_reg [NG2];
    logic [6:0]    mid_next [NG2];
    logic [CW-1:0] total_reg;
    logic [CW-1:0] total_next;

    assign pad = pad_t'(bits);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                grp_next[g] = grp_next[g] + {3'b000, pad[g*8+b]};
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < NG2; m++)
        begin
            mid_next[m] = '0;
            for (int k = 0; k < 8; k++)
            begin
                mid_next[m] = mid_next[m] + {3'b000, grp_reg[m*8+k]};
            end
        end
    end

    always_comb
    begin
        logic [8:0] acc;
        acc = '0;
        for (int m = 0; m < NG2; m++)
        begin
            acc = acc + {2'b00, mid_reg[m]};
        end
        total_next = CW'(acc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg   <= grp_next;
            mid_reg   <= mid_next;
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

@@ verif/k_mismatch_motif_search_test.sv @@
module k_mismatch_motif_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOTIF_DEPTH    = 64;
    localparam int READ_LIMIT     = 128;
    localparam int RANDOM_ITEMS   = 740;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 5 deep, plus margin
    localparam int HOLD_CYCLES    = 400;   // long output stall, fills the pipe
    localparam int WATCHDOG_LIMIT = 2000;

    // Register settings for the first random phases; extremes and clamped values
    // included. Later phases draw small settings.
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_LEN   [PHASE_COUNT] = '{64, 3, 6, 2, 127, 5, 0, 10, 1, 8};
    localparam int PHASE_ALLOW [PHASE_COUNT] = '{64, 0, 1, 0, 0, 127, 0, 2, 0, 3};
    localparam int PRESSURE_PHASE = 2;

    // one input item, as the block sees it
    typedef struct packed {
        logic            op;
        kmms_pkg::char_t ch;
        kmms_pkg::slot_t slot;
        logic            last;
    } stim_t;

    // one search result
    typedef struct packed {
        logic             found;
        kmms_pkg::start_t start;
        kmms_pkg::count_t mm;
    } hit_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // directed table row: an item (optionally with its result typed in) or a
    // register write
    typedef struct packed {
        row_kind_t            kind;
        kmms_pkg::reg_index_t reg_idx;
        logic [6:0]           reg_val;
        stim_t                item;
        logic                 typed;
        hit_t                 want;
    } dir_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_wr_en     = 1'b0;
    logic [0:0]  cfg_index     = '0;
    logic [6:0]  cfg_data      = '0;

    k_mismatch_motif_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Search predictor: own copy of motif, window history and best hit.
    // ------------------------------------------------------------------
    kmms_pkg::char_t motif_copy  [MOTIF_DEPTH];
    kmms_pkg::char_t read_window [MOTIF_DEPTH];   // last read chars, by position mod depth
    int unsigned     chars_in_read;
    logic            best_seen;
    int unsigned     best_at;
    int unsigned     best_mm;
    logic [6:0]      motif_len_reg = 7'd1;
    logic [6:0]      allowance_reg = 7'd0;

    hit_t pending_hits [$];   // results still owed by the block, oldest first

    int items_sent    = 0;
    int error_count   = 0;
    int send_streak   = 0;
    int take_streak   = 0;
    bit hold_request  = 1'b0;
    bit holding       = 1'b0;
    int idle_cycles   = 0;

    // length 0 behaves as 1, anything past the store depth as the full store
    function automatic int motif_span(logic [6:0] len);
        if (len == 0)
            return 1;
        if (len > MOTIF_DEPTH)
            return MOTIF_DEPTH;
        return len;
    endfunction

    // Advance the predictor by one item; returns 1 with the result when the
    // item closes a read.
    function automatic bit scan_item(stim_t it, output hit_t res);
        int unsigned span;
        int unsigned first;
        int unsigned mm;
        res = '0;
        if (it.op == kmms_pkg::OP_MOTIF_LOAD)
        begin
            motif_copy[it.slot] = it.ch;   // tlast on a motif item means nothing
            return 1'b0;
        end
        // chars past the read limit are dropped, but tlast still closes the read
        if (chars_in_read < READ_LIMIT)
        begin
            read_window[chars_in_read % MOTIF_DEPTH] = it.ch;
            chars_in_read++;
            span = motif_span(motif_len_reg);
            if (chars_in_read >= span)
            begin
                first = chars_in_read - span;
                mm = 0;
                for (int i = 0; i < span; i++)
                    if (read_window[(first + i) % MOTIF_DEPTH] != motif_copy[i])
                        mm++;
                // strict less-than keeps the earliest start on a tie
                if (mm <= allowance_reg && (!best_seen || mm < best_mm))
                begin
                    best_seen = 1'b1;
                    best_at   = first;
                    best_mm   = mm;
                end
            end
        end
        if (!it.last)
            return 1'b0;
        res.found = best_seen;
        res.start = best_seen ? kmms_pkg::start_t'(best_at) : '0;
        res.mm    = best_seen ? kmms_pkg::count_t'(best_mm) : '0;
        foreach (read_window[i])
            read_window[i] = '0;
        chars_in_read = 0;
        best_seen     = 1'b0;
        best_at       = 0;
        best_mm       = 0;
        return 1'b1;
    endfunction

    // Per-item random wait, with the odd stretch of back-to-back items.
    function automatic int draw_gap(inout int streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            streak = $urandom_range(15, 40);
        return $urandom_range(0, 13);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one item and hold it until taken; the predictor sees it on acceptance.
    task automatic send_item(stim_t it, logic typed, hit_t want);
        int   gap;
        hit_t got;
        gap = holding ? 0 : draw_gap(send_streak);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.slot, it.ch};
        s_axis_tuser  <= it.op;
        s_axis_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (scan_item(it, got))
        begin
            pending_hits.push_back(typed ? want : got);
        end
    endtask

    // Registers change only with the block idle: everything owed has come out
    // and the pipe has had time to empty.
    task automatic write_register(kmms_pkg::reg_index_t idx, logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == kmms_pkg::REG_MOTIF_LENGTH)
            motif_len_reg = value;
        else
            allowance_reg = value;
    endtask

    // directed table row builders
    function automatic dir_row_t load_row(kmms_pkg::slot_t slot, kmms_pkg::char_t ch,
                                          logic last);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.item = '{op: kmms_pkg::OP_MOTIF_LOAD, ch: ch, slot: slot, last: last};
        return row;
    endfunction

    function automatic dir_row_t char_row(kmms_pkg::char_t ch, logic last);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.item = '{op: kmms_pkg::OP_READ_CHAR, ch: ch, slot: '0, last: last};
        return row;
    endfunction

    function automatic dir_row_t known_row(kmms_pkg::char_t ch, logic found,
                                           kmms_pkg::start_t start, kmms_pkg::count_t mm);
        dir_row_t row;
        row       = char_row(ch, 1'b1);
        row.typed = 1'b1;
        row.want  = '{found: found, start: start, mm: mm};
        return row;
    endfunction

    function automatic dir_row_t reg_row(kmms_pkg::reg_index_t idx, logic [6:0] value);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = value;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : take_results
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                holding      = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                gap = draw_gap(take_streak);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: tuser %b tdata %h",
                                          m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_axis_tuser[0] !== want.found)
                    report_mismatch($sformatf("found: got %b, want %b",
                                              m_axis_tuser[0], want.found));
                if (m_axis_tdata[6:0] !== want.start)
                    report_mismatch($sformatf("match_start: got %0d, want %0d",
                                              m_axis_tdata[6:0], want.start));
                if (m_axis_tdata[13:7] !== want.mm)
                    report_mismatch($sformatf("mismatch_count: got %0d, want %0d",
                                              m_axis_tdata[13:7], want.mm));
            end
        end
    end

    // Watchdog: too long with no item moving on either side means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t        dir_table [$];
        stim_t           it;
        int              random_start;
        int              phase;
        int              phase_start;
        int              len_val;
        int              allow_val;
        int              span;
        int              pick;
        int              read_len;
        int              plant_at;
        int              flips;
        kmms_pkg::char_t ch;

        foreach (motif_copy[i])
            motif_copy[i] = '0;
        foreach (read_window[i])
            read_window[i] = '0;
        chars_in_read = 0;
        best_seen     = 1'b0;
        best_at       = 0;
        best_mm       = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Only slot 0 is compared at length 1, so it is loaded
        // first; slots 1..3 are loaded after the length goes to 4, before the next read.
        dir_table = '{
            load_row(6'd0, 8'h00, 1'b0),
            load_row(6'd63, 8'hFF, 1'b0),
            known_row(8'h00, 1'b1, 7'd0, 7'd0),           // exact hit
            known_row(8'hFF, 1'b0, 7'd0, 7'd0),           // miss, zero allowance
            char_row(8'hFF, 1'b0),
            known_row(8'h00, 1'b1, 7'd1, 7'd0),           // hit at second start
            load_row(6'd5, 8'h11, 1'b1),                  // motif item with tlast: no result
            reg_row(kmms_pkg::REG_MOTIF_LENGTH, 7'd0),    // zero length acts as one
            known_row(8'h00, 1'b1, 7'd0, 7'd0),
            reg_row(kmms_pkg::REG_MOTIF_LENGTH, 7'd4),
            reg_row(kmms_pkg::REG_MISMATCH_ALLOWANCE, 7'd1),
            load_row(6'd1, 8'h41, 1'b0),
            load_row(6'd2, 8'h42, 1'b0),
            load_row(6'd3, 8'h43, 1'b0),
            known_row(8'h41, 1'b0, 7'd0, 7'd0),           // read shorter than motif
            char_row(8'h00, 1'b0),
            char_row(8'h41, 1'b0),
            char_row(8'h42, 1'b0),
            char_row(8'h43, 1'b0),
            known_row(8'h00, 1'b1, 7'd0, 7'd0),
            char_row(8'h00, 1'b0),
            load_row(6'd3, 8'h44, 1'b0),                  // motif change mid-read
            char_row(8'h41, 1'b0),
            char_row(8'h42, 1'b0),
            char_row(8'h43, 1'b1),
            reg_row(kmms_pkg::REG_MISMATCH_ALLOWANCE, 7'd127),  // allowance beyond length
            char_row(8'hFF, 1'b0),
            char_row(8'hFF, 1'b0),
            char_row(8'hFF, 1'b0),
            known_row(8'hFF, 1'b1, 7'd0, 7'd4)
        };
        foreach (dir_table[r])
        begin
            if (dir_table[r].kind == ROW_REG)
                write_register(dir_table[r].reg_idx, dir_table[r].reg_val);
            else
                send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].want);
        end

        // Random part. Fill the whole motif store first so that no window can
        // ever see an entry that was never written.
        random_start = items_sent;
        for (int s = 0; s < MOTIF_DEPTH; s++)
        begin
            it = '{op: kmms_pkg::OP_MOTIF_LOAD,
                   ch: kmms_pkg::char_t'($urandom_range(0, 255)),
                   slot: kmms_pkg::slot_t'(s), last: 1'($urandom_range(0, 1))};
            send_item(it, 1'b0, '0);
        end

        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (phase < PHASE_COUNT)
            begin
                len_val   = PHASE_LEN[phase];
                allow_val = PHASE_ALLOW[phase];
            end
            else
            begin
                len_val   = $urandom_range(1, 10);
                allow_val = $urandom_range(0, 3);
            end
            write_register(kmms_pkg::REG_MOTIF_LENGTH, 7'(len_val));
            write_register(kmms_pkg::REG_MISMATCH_ALLOWANCE, 7'(allow_val));
            if (phase == PRESSURE_PHASE)
                hold_request = 1'b1;
            span = motif_span(7'(len_val));
            phase_start = items_sent;

            // whole reads only, so the block is idle at the next register write
            while (items_sent - phase_start < 60)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    read_len = $urandom_range(1, span);              // often too short
                else if (pick == 1)
                    read_len = $urandom_range(READ_LIMIT - 8, READ_LIMIT + 12);
                else
                    read_len = span + $urandom_range(0, 12);
                // plant a near copy of the motif, except in pure-noise reads
                plant_at = (pick == 2 || read_len < span) ? read_len
                                                          : $urandom_range(0, read_len - span);
                flips = $urandom_range(0, (allow_val < 4) ? allow_val + 1 : 4);
                for (int c = 0; c < read_len; c++)
                begin
                    if ($urandom_range(0, 39) == 0)
                    begin
                        // stray motif write in the middle of a read
                        it = '{op: kmms_pkg::OP_MOTIF_LOAD,
                               ch: kmms_pkg::char_t'($urandom_range(0, 255)),
                               slot: kmms_pkg::slot_t'($urandom_range(0, MOTIF_DEPTH - 1)),
                               last: 1'($urandom_range(0, 1))};
                        send_item(it, 1'b0, '0);
                    end
                    if (c >= plant_at && c < plant_at + span)
                    begin
                        ch = motif_copy[c - plant_at];
                        if ($urandom_range(0, span - 1) < flips)
                            ch = ch ^ kmms_pkg::char_t'($urandom_range(1, 255));
                    end
                    else if ($urandom_range(0, 2) == 0)
                        ch = kmms_pkg::char_t'($urandom_range(0, 255));
                    else
                        ch = motif_copy[$urandom_range(0, span - 1)];
                    it = '{op: kmms_pkg::OP_READ_CHAR, ch: ch,
                           slot: kmms_pkg::slot_t'($urandom_range(0, MOTIF_DEPTH - 1)),
                           last: (c == read_len - 1)};
                    send_item(it, 1'b0, '0);
                end
            end
            phase++;
        end

        // drain, then give the pipe time to show any stray result
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_hits.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
